FILE: rtl/spc_pkg.sv
// Shared types, register codes and helper functions of the sphere particle collider.
`default_nettype none
package spc_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_RADIUS    = 3'd3,
    REG_CONTROL   = 3'd4,
    REG_SMOOTH    = 3'd5,
    REG_BOUNCE    = 3'd6,
    REG_HIT_COLOR = 3'd7
  } reg_idx_t;

  // Bit positions inside the control register.
  localparam int unsigned CtlInvert  = 0;
  localparam int unsigned CtlKiller  = 1;
  localparam int unsigned CtlNoResol = 2;
  localparam int unsigned CtlColor   = 3;
  localparam int unsigned CtlEnable  = 4;

  // Number of items the queue between front and back can hold.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Register file contents as seen by both halves.
  typedef struct packed {
    logic [2:0][31:0]   center;
    logic [30:0]        radius;
    logic [4:0]         control;
    logic signed [15:0] smooth;
    logic signed [15:0] bounce;
    logic [31:0]        hit_color;
  } cfg_t;

  // One classified item handed from front to back.
  typedef struct packed {
    logic             kind;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] last;
    logic [2:0][32:0] diff;
    logic [65:0]      dist_sq;
    logic             hit;
    logic             kill;
    logic             color;
    logic             resolve;
    logic [31:0]      base;
    logic [31:0]      coll;
    logic [31:0]      ticks;
  } entry_t;

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Magnitude of a 33-bit signed difference; always fits in 32 bits.
  function automatic logic [31:0] mag33(input logic [32:0] d);
    logic [32:0] m;
    m = d[32] ? (33'd0 - d) : d;
    return m[31:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/spc_intf.sv
// Channel interfaces of the sphere particle collider: input, result and configuration.
`default_nettype none
interface spc_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] last_x;
  logic signed [31:0] last_y;
  logic signed [31:0] last_z;
  logic               already_collided;
  logic [31:0]        frame_count;

  modport source(output valid, kind, pos_x, pos_y, pos_z, last_x, last_y, last_z,
                 already_collided, frame_count, input ready);
  modport sink(input valid, kind, pos_x, pos_y, pos_z, last_x, last_y, last_z,
               already_collided, frame_count, output ready);
endinterface

interface spc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_last_x;
  logic signed [31:0] new_last_y;
  logic signed [31:0] new_last_z;
  logic               hit;
  logic               kill;
  logic               apply_color;
  logic [31:0]        base_frame;
  logic [31:0]        collision_total;
  logic [31:0]        ticks_idle;

  modport source(output valid, new_pos_x, new_pos_y, new_pos_z, new_last_x, new_last_y,
                 new_last_z, hit, kill, apply_color, base_frame, collision_total,
                 ticks_idle, input ready);
  modport sink(input valid, new_pos_x, new_pos_y, new_pos_z, new_last_x, new_last_y,
               new_last_z, hit, kill, apply_color, base_frame, collision_total,
               ticks_idle, output ready);
endinterface

interface spc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/spc_front.sv
// Front half: register file, item intake, squared distance, hit test and counters.
`default_nettype none
module spc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  spc_in_if.sink               in_ch,
  spc_cfg_if.sink              cfg_ch,
  output spc_pkg::cfg_t        cfg,
  output spc_pkg::entry_t      q_data,
  output logic                 q_push,
  input  wire logic            q_full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SQ   = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t          state_r, state_nxt;
  spc_pkg::cfg_t    cfg_r;
  logic             kind_r;
  logic [2:0][31:0] pos_r;
  logic [2:0][31:0] last_r;
  logic [2:0][32:0] diff_r;
  logic             ac_r;
  logic [31:0]      fc_r;
  logic [1:0]       sq_cnt_r;
  logic [65:0]      acc_r;
  logic [61:0]      rsq_r;
  logic [31:0]      coll_r, coll_nxt;
  logic [31:0]      tick_r, tick_nxt;

  logic [31:0] sq_op;
  logic [63:0] sq_prod;
  logic        hit_c, killer, en;
  logic [2:0][31:0] ctr_in;

  assign cfg          = cfg_r;
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == F_IDLE);

  // Configuration writes; the user must write only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center    <= '0;
      cfg_r.radius    <= 31'd65536;
      cfg_r.control   <= 5'd16;
      cfg_r.smooth    <= 16'sd4096;
      cfg_r.bounce    <= '0;
      cfg_r.hit_color <= '0;
    end else if (cfg_ch.valid) begin
      unique case (spc_pkg::reg_idx_t'(cfg_ch.index))
        spc_pkg::REG_CENTER_X:  cfg_r.center[0] <= cfg_ch.data;
        spc_pkg::REG_CENTER_Y:  cfg_r.center[1] <= cfg_ch.data;
        spc_pkg::REG_CENTER_Z:  cfg_r.center[2] <= cfg_ch.data;
        spc_pkg::REG_RADIUS:    cfg_r.radius    <= cfg_ch.data[30:0];
        spc_pkg::REG_CONTROL:   cfg_r.control   <= cfg_ch.data[4:0];
        spc_pkg::REG_SMOOTH:    cfg_r.smooth    <= cfg_ch.data[15:0];
        spc_pkg::REG_BOUNCE:    cfg_r.bounce    <= cfg_ch.data[15:0];
        spc_pkg::REG_HIT_COLOR: cfg_r.hit_color <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // One shared multiplier forms the three squares and then the radius squared.
  always_comb begin
    case (sq_cnt_r)
      2'd0:    sq_op = spc_pkg::mag33(diff_r[0]);
      2'd1:    sq_op = spc_pkg::mag33(diff_r[1]);
      2'd2:    sq_op = spc_pkg::mag33(diff_r[2]);
      default: sq_op = {1'b0, cfg_r.radius};
    endcase
    sq_prod = sq_op * sq_op;
  end

  // Hit test against the sphere, solid or inverted into a cavity.
  assign en     = cfg_r.control[spc_pkg::CtlEnable] && !kind_r;
  assign killer = cfg_r.control[spc_pkg::CtlKiller];
  always_comb begin
    if (cfg_r.control[spc_pkg::CtlInvert]) begin
      hit_c = en && (acc_r > {4'd0, rsq_r});
    end else begin
      hit_c = en && (acc_r < {4'd0, rsq_r});
    end
  end

  // Counters as they stand after this item.
  always_comb begin
    coll_nxt = coll_r;
    tick_nxt = tick_r;
    if (kind_r) begin
      if (tick_r != 32'hFFFFFFFF) tick_nxt = tick_r + 32'd1;
    end else if (hit_c) begin
      tick_nxt = '0;
      if (coll_r != 32'hFFFFFFFF) coll_nxt = coll_r + 32'd1;
    end
  end

  // Classified item for the queue.
  assign ctr_in = {cfg_r.center[2], cfg_r.center[1], cfg_r.center[0]};
  always_comb begin
    q_data.kind    = kind_r;
    q_data.pos     = kind_r ? '0 : pos_r;
    q_data.last    = kind_r ? '0 : last_r;
    q_data.diff    = diff_r;
    q_data.dist_sq = acc_r;
    q_data.hit     = hit_c;
    q_data.kill    = hit_c && killer;
    q_data.color   = hit_c && !killer && cfg_r.control[spc_pkg::CtlColor];
    q_data.resolve = hit_c && !killer && !cfg_r.control[spc_pkg::CtlNoResol];
    q_data.base    = (hit_c && !ac_r) ? fc_r : '0;
    q_data.coll    = coll_nxt;
    q_data.ticks   = tick_nxt;
  end

  assign q_push = (state_r == F_PUSH) && !q_full;

  // Sequencer of the front half.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_ch.valid) state_nxt = in_ch.kind ? F_PUSH : F_SQ;
      F_SQ:   if (sq_cnt_r == 2'd3) state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      coll_r  <= '0;
      tick_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_push) begin
        coll_r <= coll_nxt;
        tick_r <= tick_nxt;
      end
    end
  end

  // Item registers and the squared-distance accumulator.
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_ch.valid) begin
      kind_r   <= in_ch.kind;
      pos_r    <= {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
      last_r   <= {in_ch.last_z, in_ch.last_y, in_ch.last_x};
      ac_r     <= in_ch.already_collided;
      fc_r     <= in_ch.frame_count;
      diff_r[0] <= {in_ch.pos_x[31], in_ch.pos_x} - {ctr_in[0][31], ctr_in[0]};
      diff_r[1] <= {in_ch.pos_y[31], in_ch.pos_y} - {ctr_in[1][31], ctr_in[1]};
      diff_r[2] <= {in_ch.pos_z[31], in_ch.pos_z} - {ctr_in[2][31], ctr_in[2]};
      sq_cnt_r <= '0;
      acc_r    <= '0;
      rsq_r    <= '0;
    end else if (state_r == F_SQ) begin
      sq_cnt_r <= sq_cnt_r + 2'd1;
      if (sq_cnt_r == 2'd3) begin
        rsq_r <= sq_prod[61:0];
      end else begin
        acc_r <= acc_r + {2'd0, sq_prod};
      end
    end
  end

  // A hit always clears the idle tick count that travels with it.
  a_hit_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_data.hit) |-> (q_data.ticks == 32'd0))
    else $error("hit item left with nonzero tick count");

  // Collision total only moves by one, and only on a pushed hit.
  a_coll_step: assert property (@(posedge clk) disable iff (!rst_n)
    (coll_r != $past(coll_r)) |-> ($past(q_push) && $past(q_data.hit)))
    else $error("collision counter moved without a hit");

endmodule
`default_nettype wire

FILE: rtl/spc_queue.sv
// Short queue of classified items between the front and back halves.
`default_nettype none
module spc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire spc_pkg::entry_t wr_data,
  input  wire logic            push,
  output logic                 full,
  output spc_pkg::entry_t      rd_data,
  input  wire logic            pop,
  output logic                 empty
);

  spc_pkg::entry_t                  slot_r [spc_pkg::QDepth];
  logic [spc_pkg::QPtrW-1:0]        wr_ptr_r, rd_ptr_r;
  logic [spc_pkg::QCntW-1:0]        cnt_r;

  assign full    = (cnt_r == spc_pkg::QCntW'(spc_pkg::QDepth));
  assign empty   = (cnt_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_data;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("item written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("item taken from an empty queue");

endmodule
`default_nettype wire

FILE: rtl/spc_back.sv
// Back half: square root, normal division and the push and velocity rebuild sequence.
`default_nettype none
module spc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire spc_pkg::cfg_t   cfg,
  input  wire spc_pkg::entry_t q_data,
  input  wire logic            q_empty,
  output logic                 q_pop,
  spc_out_if.source            out_ch
);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_SQRT = 6'b000010,
    B_DIV  = 6'b000100,
    B_MUL  = 6'b001000,
    B_ACC  = 6'b010000,
    B_OUT  = 6'b100000
  } bstate_t;

  typedef enum logic [2:0] {
    P_PUSH = 3'd0,
    P_DOT  = 3'd1,
    P_PERP = 3'd2,
    P_SM   = 3'd3,
    P_BO   = 3'd4
  } phase_t;

  bstate_t          state_r, state_nxt;
  phase_t           phase_r;
  logic [1:0]       lane_r;
  spc_pkg::entry_t  ent_r;
  logic [5:0]       cnt_r;

  // Square root registers.
  logic [65:0] sq_r;
  logic [32:0] root_r;
  logic [33:0] srem_r;

  // Division lanes.
  logic [32:0] drem_r [3];
  logic        nb_r   [3];
  logic [30:0] quo_r  [3];

  // Resolve registers.
  logic signed [31:0] pos_r   [3];
  logic signed [31:0] last_r  [3];
  logic signed [33:0] v_r     [3];
  logic signed [35:0] vperp_r [3];
  logic signed [36:0] vpar_r  [3];
  logic signed [40:0] t_r     [3];
  logic signed [35:0] dot_r;
  logic [69:0]        prod_r;
  logic               neg_r;
  logic               sh30_r;

  // Combinational helpers.
  logic [35:0]        s_shift, s_trial;
  logic               s_take;
  logic [32:0]        root_nxt;
  logic [31:0]        dmag_c  [3];
  logic [33:0]        d_shift [3];
  logic               d_take  [3];
  logic signed [31:0] n_c     [3];
  logic signed [34:0] delta_c;
  logic signed [37:0] a_sel;
  logic signed [31:0] b_sel;
  logic [37:0]        a_mag;
  logic [31:0]        b_mag;
  logic [70:0]        rsum, rsh;
  logic signed [47:0] rval;
  logic signed [47:0] w_pos, w_last, w_t;
  logic signed [31:0] np_c, nl_c;
  logic               last_step;

  // Square root: two radicand bits per cycle, one root bit per cycle.
  assign s_shift  = {srem_r, sq_r[65:64]};
  assign s_trial  = {1'b0, root_r, 2'b01};
  assign s_take   = (s_shift >= s_trial);
  assign root_nxt = {root_r[31:0], s_take};

  // Division lanes: one quotient bit of each normal component per cycle.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag_c[i]  = spc_pkg::mag33(ent_r.diff[i]);
      d_shift[i] = {drem_r[i], nb_r[i]};
      d_take[i]  = (d_shift[i] >= {1'b0, root_r});
      n_c[i]     = ent_r.diff[i][32] ? -$signed({1'b0, quo_r[i]}) : $signed({1'b0, quo_r[i]});
    end
  end

  assign delta_c = $signed({2'b00, root_r}) - $signed({4'b0000, cfg.radius});

  // Operand selection for the shared multiplier.
  always_comb begin
    a_sel = '0;
    b_sel = n_c[lane_r];
    case (phase_r)
      P_PUSH: a_sel = delta_c;
      P_DOT:  a_sel = v_r[lane_r];
      P_PERP: a_sel = dot_r;
      P_SM: begin
        a_sel = vpar_r[lane_r];
        b_sel = cfg.smooth;
      end
      P_BO: begin
        a_sel = vperp_r[lane_r];
        b_sel = cfg.bounce;
      end
      default: ;
    endcase
    a_mag = a_sel[37] ? 38'(-a_sel) : 38'(a_sel);
    b_mag = b_sel[31] ? 32'(-b_sel) : 32'(b_sel);
  end

  // Round to nearest, ties away from zero, then restore the sign.
  always_comb begin
    rsum = {1'b0, prod_r} + (sh30_r ? (71'd1 << 29) : (71'd1 << 11));
    rsh  = sh30_r ? (rsum >> 30) : (rsum >> 12);
    rval = neg_r ? -$signed({1'b0, rsh[46:0]}) : $signed({1'b0, rsh[46:0]});
    w_pos  = pos_r[lane_r];
    w_last = last_r[lane_r];
    w_t    = t_r[lane_r];
    np_c   = spc_pkg::sat32(w_pos - rval);
    nl_c   = spc_pkg::sat32(w_last - rval);
  end

  assign last_step = (phase_r == P_BO) && (lane_r == 2'd2);
  assign q_pop     = (state_r == B_IDLE) && !q_empty;

  // Sequencer of the back half.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_empty) state_nxt = q_data.resolve ? B_SQRT : B_OUT;
      B_SQRT: if (cnt_r == '0) state_nxt = (root_nxt == '0) ? B_OUT : B_DIV;
      B_DIV:  if (cnt_r == '0) state_nxt = B_MUL;
      B_MUL:  state_nxt = B_ACC;
      B_ACC:  state_nxt = last_step ? B_OUT : B_MUL;
      B_OUT:  if (out_ch.ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        ent_r  <= q_data;
        sq_r   <= q_data.dist_sq;
        root_r <= '0;
        srem_r <= '0;
        cnt_r  <= 6'd32;
        for (int i = 0; i < 3; i++) begin
          pos_r[i]  <= q_data.pos[i];
          last_r[i] <= q_data.last[i];
        end
      end
      B_SQRT: begin
        sq_r   <= {sq_r[63:0], 2'b00};
        root_r <= root_nxt;
        srem_r <= s_take ? 34'(s_shift - s_trial) : s_shift[33:0];
        if (cnt_r == '0) begin
          cnt_r <= 6'd30;
          for (int i = 0; i < 3; i++) begin
            drem_r[i] <= {2'b00, dmag_c[i][31:1]};
            nb_r[i]   <= dmag_c[i][0];
            quo_r[i]  <= '0;
          end
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
      B_DIV: begin
        cnt_r <= cnt_r - 6'd1;
        for (int i = 0; i < 3; i++) begin
          drem_r[i] <= d_take[i] ? 33'(d_shift[i] - {1'b0, root_r}) : d_shift[i][32:0];
          nb_r[i]   <= 1'b0;
          quo_r[i]  <= {quo_r[i][29:0], d_take[i]};
        end
        phase_r <= P_PUSH;
        lane_r  <= '0;
        dot_r   <= '0;
      end
      B_MUL: begin
        prod_r <= a_mag * b_mag;
        neg_r  <= a_sel[37] ^ b_sel[31];
        sh30_r <= (phase_r == P_PUSH) || (phase_r == P_DOT) || (phase_r == P_PERP);
      end
      B_ACC: begin
        case (phase_r)
          P_PUSH: begin
            pos_r[lane_r]  <= np_c;
            last_r[lane_r] <= nl_c;
            v_r[lane_r]    <= $signed({np_c[31], np_c[31], np_c}) -
                              $signed({nl_c[31], nl_c[31], nl_c});
          end
          P_DOT:  dot_r <= dot_r + rval[35:0];
          P_PERP: begin
            vperp_r[lane_r] <= rval[35:0];
            vpar_r[lane_r]  <= 37'(v_r[lane_r]) - 37'($signed(rval[35:0]));
          end
          P_SM:   t_r[lane_r] <= 41'(w_pos - rval);
          P_BO:   last_r[lane_r] <= spc_pkg::sat32(w_t + rval);
          default: ;
        endcase
        if (lane_r == 2'd2) begin
          lane_r  <= '0;
          phase_r <= phase_t'(phase_r + 3'd1);
        end else begin
          lane_r <= lane_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // Result register view.
  assign out_ch.valid           = (state_r == B_OUT);
  assign out_ch.new_pos_x       = pos_r[0];
  assign out_ch.new_pos_y       = pos_r[1];
  assign out_ch.new_pos_z       = pos_r[2];
  assign out_ch.new_last_x      = last_r[0];
  assign out_ch.new_last_y      = last_r[1];
  assign out_ch.new_last_z      = last_r[2];
  assign out_ch.hit             = ent_r.hit;
  assign out_ch.kill            = ent_r.kill;
  assign out_ch.apply_color     = ent_r.color;
  assign out_ch.base_frame      = ent_r.base;
  assign out_ch.collision_total = ent_r.coll;
  assign out_ch.ticks_idle      = ent_r.ticks;

  // Division only runs on a nonzero distance.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (root_r != '0))
    else $error("normal division started with zero distance");

  // A killed particle never asks for colour.
  a_kill_no_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.kill && out_ch.apply_color))
    else $error("killed particle flagged for colour");

endmodule
`default_nettype wire

FILE: rtl/sphere_particle_collision_top.sv
// Top level of the sphere particle collider: front half, queue and back half.
//
// Channels: in_ch takes particle items (kind 0) and tick items (kind 1);
// out_ch returns exactly one result item per input item, in order; cfg_ch
// writes the eight registers and is always ready. Positions, the centre and
// the radius are Q16.16; smooth and bounce are signed Q4.12.
// Flow: the front half takes an item, forms the three squares and the radius
// squared on the shared squaring multiplier and classifies it; it takes no
// new item until the last one is in the queue. A tick item skips the squares.
// Items that need no surface resolve go from the queue straight to the result
// register. A resolved particle passes in the back half through intake, the
// bit-serial square root, the three parallel normal division lanes, fifteen
// multiply and round steps on one shared multiplier and the result register;
// the back half sets the sustained rate while such particles arrive.
// Reset: rst_n is synchronous and active low; it restores the register
// defaults and clears the collision and tick counters and the queue.
// Stalls: when out_ch.ready is low the result is held, the back half stops
// and the two-item queue fills; the front half then holds its item and
// in_ch.ready stays low.
`default_nettype none
module sphere_particle_collision_top (
  input  wire logic clk,
  input  wire logic rst_n,
  spc_in_if.sink    in_ch,
  spc_out_if.source out_ch,
  spc_cfg_if.sink   cfg_ch
);

  spc_pkg::cfg_t   cfg;
  spc_pkg::entry_t f_data;
  spc_pkg::entry_t b_data;
  logic            q_push, q_full, q_pop, q_empty;

  // Intake and classification.
  spc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .cfg    (cfg),
    .q_data (f_data),
    .q_push (q_push),
    .q_full (q_full)
  );

  // Decoupling queue.
  spc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_data (f_data),
    .push    (q_push),
    .full    (q_full),
    .rd_data (b_data),
    .pop     (q_pop),
    .empty   (q_empty)
  );

  // Resolution and result register.
  spc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_data  (b_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
